FILE: rtl/gpq_pkg.sv
package gpq_pkg;

    localparam int BTN_W    = 10;
    localparam int AXIS_W   = 8;
    localparam int CNT_W    = 8;
    localparam int NUM_DIRS = 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Direction bit positions within the button word
    localparam int DIR_UP    = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_DOWN  = 2;
    localparam int DIR_LEFT  = 3;

    // Register word indexes (byte address / 4)
    localparam logic [2:0] REG_FULL_LOW    = 3'd0;
    localparam logic [2:0] REG_HALF_LOW    = 3'd1;
    localparam logic [2:0] REG_HALF_HIGH   = 3'd2;
    localparam logic [2:0] REG_FULL_HIGH   = 3'd3;
    localparam logic [2:0] REG_REPEAT_DLY  = 3'd4;

    localparam logic [AXIS_W-1:0] RST_FULL_LOW   = 8'h10;
    localparam logic [AXIS_W-1:0] RST_HALF_LOW   = 8'h40;
    localparam logic [AXIS_W-1:0] RST_HALF_HIGH  = 8'hc0;
    localparam logic [AXIS_W-1:0] RST_FULL_HIGH  = 8'hf0;
    localparam logic [CNT_W-1:0]  RST_REPEAT_DLY = 8'd6;

    // Low bits of a hold count that must be zero for a repeat strobe
    localparam logic [2:0] REPEAT_MOD_MASK = 3'd7;

    typedef struct packed {
        logic [AXIS_W-1:0] full_low;
        logic [AXIS_W-1:0] half_low;
        logic [AXIS_W-1:0] half_high;
        logic [AXIS_W-1:0] full_high;
        logic [CNT_W-1:0]  repeat_delay;
    } cfg_t;

    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic              other_active;
        logic [AXIS_W-1:0] stick_x;
        logic [AXIS_W-1:0] stick_y;
    } item_t;

    typedef struct packed {
        logic [BTN_W-1:0]                 held;
        logic [BTN_W-1:0]                 changed;
        logic [BTN_W-1:0]                 pressed;
        logic                             any_active;
        logic [NUM_DIRS-1:0]              repeat_res;
        logic [NUM_DIRS-1:0][CNT_W-1:0]   hold_cnt;
    } res_t;

    // Sort one axis into its zone: bit 0 low direction, bit 1 high direction
    function automatic logic [1:0] axis_zone(input logic [AXIS_W-1:0] v,
                                             input logic phase,
                                             input cfg_t cfg);
        logic [1:0] z;
        if (v < cfg.full_low)
            z = 2'b01;
        else if (v < cfg.half_low)
            z = {1'b0, phase};
        else if (v < cfg.half_high)
            z = 2'b00;
        else if (v < cfg.full_high)
            z = {phase, 1'b0};
        else
            z = 2'b10;
        return z;
    endfunction

endpackage

FILE: rtl/gpq_cfg.sv
module gpq_cfg
    import gpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] word_idx;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite;
    assign word_idx = paddr[4:2];
    assign cfg      = cfg_reg;

    // Write the addressed register; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_low     <= RST_FULL_LOW;
            cfg_reg.half_low     <= RST_HALF_LOW;
            cfg_reg.half_high    <= RST_HALF_HIGH;
            cfg_reg.full_high    <= RST_FULL_HIGH;
            cfg_reg.repeat_delay <= RST_REPEAT_DLY;
        end
        else if (wr_en)
        begin
            case (word_idx)
                REG_FULL_LOW:   cfg_reg.full_low     <= pwdata[AXIS_W-1:0];
                REG_HALF_LOW:   cfg_reg.half_low     <= pwdata[AXIS_W-1:0];
                REG_HALF_HIGH:  cfg_reg.half_high    <= pwdata[AXIS_W-1:0];
                REG_FULL_HIGH:  cfg_reg.full_high    <= pwdata[AXIS_W-1:0];
                REG_REPEAT_DLY: cfg_reg.repeat_delay <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (word_idx)
            REG_FULL_LOW:   prdata = {{(DATA_W-AXIS_W){1'b0}}, cfg_reg.full_low};
            REG_HALF_LOW:   prdata = {{(DATA_W-AXIS_W){1'b0}}, cfg_reg.half_low};
            REG_HALF_HIGH:  prdata = {{(DATA_W-AXIS_W){1'b0}}, cfg_reg.half_high};
            REG_FULL_HIGH:  prdata = {{(DATA_W-AXIS_W){1'b0}}, cfg_reg.full_high};
            REG_REPEAT_DLY: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.repeat_delay};
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: rtl/gpq_core.sv
module gpq_core
    import gpq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    logic                           phase_reg;
    logic [BTN_W-1:0]               prev_held_reg;
    logic [NUM_DIRS-1:0][CNT_W-1:0] cnt_reg;

    logic                           phase_next;
    logic [1:0]                     zone_x;
    logic [1:0]                     zone_y;
    logic [NUM_DIRS-1:0]            dir_bits;
    logic [BTN_W-1:0]               held_now;
    logic [BTN_W-1:0]               changed_now;
    logic [NUM_DIRS-1:0][CNT_W-1:0] cnt_next;
    logic [NUM_DIRS-1:0]            rep_now;

    // Toggle the phase first; the new phase gates the pulsing zones
    assign phase_next = ~phase_reg;
    assign zone_y     = axis_zone(item.stick_y, phase_next, cfg);
    assign zone_x     = axis_zone(item.stick_x, phase_next, cfg);

    // Merge stick directions into the button word
    always_comb
    begin
        dir_bits            = '0;
        dir_bits[DIR_UP]    = zone_y[0];
        dir_bits[DIR_DOWN]  = zone_y[1];
        dir_bits[DIR_LEFT]  = zone_x[0];
        dir_bits[DIR_RIGHT] = zone_x[1];
    end

    assign held_now    = item.buttons | {{(BTN_W-NUM_DIRS){1'b0}}, dir_bits};
    assign changed_now = held_now ^ prev_held_reg;

    // Advance the hold counters and form the repeat strobes
    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            cnt_next[d] = cnt_reg[d];
            if (held_now[d])
                cnt_next[d] = cnt_reg[d] + CNT_W'(1);
            if (changed_now[d])
                cnt_next[d] = '0;
            rep_now[d] = held_now[d] & (changed_now[d] |
                         ((cnt_next[d] > cfg.repeat_delay) &&
                          ((cnt_next[d][2:0] & REPEAT_MOD_MASK) == 3'd0)));
        end
    end

    always_comb
    begin
        res.held       = held_now;
        res.changed    = changed_now;
        res.pressed    = changed_now & held_now;
        res.any_active = (held_now != '0) | item.other_active;
        res.repeat_res = rep_now;
        res.hold_cnt   = cnt_next;
    end

    // Commit poll state when a request moves on to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            prev_held_reg <= '0;
            cnt_reg       <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            prev_held_reg <= held_now;
            cnt_reg       <= cnt_next;
        end
    end

    a_phase_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> phase_reg != $past(phase_reg))
        else $error("pulse phase did not toggle on a poll");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(prev_held_reg) && $stable(cnt_reg) && $stable(phase_reg))
        else $error("poll state moved without a poll");

    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> prev_held_reg == $past(res.held))
        else $error("previous held does not match last result");

    a_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && changed_now[DIR_UP] |=> cnt_reg[DIR_UP] == '0)
        else $error("up hold count not cleared on change");

endmodule

FILE: rtl/gamepad_input_qualifier.sv
// Gamepad input qualifier.
// Input channel: in_valid / in_stall with buttons, other_active, stick_x and
// stick_y; one request is one pad poll. Output channel: out_valid / out_stall
// with held, changed, pressed, any_active, repeat_res and the four direction
// hold counts; one result per poll, in poll order.
// Configuration: APB-style port, five 8-bit registers at byte addresses
// 0x00 full_low, 0x04 half_low, 0x08 half_high, 0x0c full_high,
// 0x10 repeat_delay. pready is always high; write only while idle.
// Path: a taken poll sits in the input register, then is qualified and loaded
// into the result register when that register is free, which raises out_valid.
// Throughput: one poll per cycle while out_stall is low, set by the single
// compare-and-increment pass between the input and result registers.
// Stall: while the result waits under out_stall the input register can
// still take one more poll; in_stall rises only when both are full.
// Reset: both registers empty, thresholds to 16/64/192/240, repeat delay 6,
// pulse phase, previous held word and hold counts to zero.
module gamepad_input_qualifier
    import gpq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [BTN_W-1:0]          buttons,
    input  logic                      other_active,
    input  logic [AXIS_W-1:0]         stick_x,
    input  logic [AXIS_W-1:0]         stick_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [BTN_W-1:0]          held,
    output logic [BTN_W-1:0]          changed,
    output logic [BTN_W-1:0]          pressed,
    output logic                      any_active,
    output logic [NUM_DIRS-1:0]       repeat_res,
    output logic [CNT_W-1:0]          up_hold,
    output logic [CNT_W-1:0]          right_hold,
    output logic [CNT_W-1:0]          down_hold,
    output logic [CNT_W-1:0]          left_hold,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res_reg;
    logic  res_valid_reg;
    res_t  res_comb;
    logic  res_free;
    logic  advance;
    logic  take_in;

    gpq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gpq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res_comb)
    );

    // Handshake: move a request on when the result register frees up
    assign res_free = ~res_valid_reg | ~out_stall;
    assign advance  = in_valid_reg & res_free;
    assign in_stall = in_valid_reg & ~res_free;
    assign take_in  = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (~out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Capture payloads; hold them while stalled
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.buttons      <= buttons;
            in_item_reg.other_active <= other_active;
            in_item_reg.stick_x      <= stick_x;
            in_item_reg.stick_y      <= stick_y;
        end
        if (advance)
            res_reg <= res_comb;
    end

    assign out_valid  = res_valid_reg;
    assign held       = res_reg.held;
    assign changed    = res_reg.changed;
    assign pressed    = res_reg.pressed;
    assign any_active = res_reg.any_active;
    assign repeat_res = res_reg.repeat_res;
    assign up_hold    = res_reg.hold_cnt[DIR_UP];
    assign right_hold = res_reg.hold_cnt[DIR_RIGHT];
    assign down_hold  = res_reg.hold_cnt[DIR_DOWN];
    assign left_hold  = res_reg.hold_cnt[DIR_LEFT];

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gpq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;
    // Index past the last register, which the block must ignore
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid;
    logic                  in_stall;
    logic [BTN_W-1:0]      buttons;
    logic                  other_active;
    logic [AXIS_W-1:0]     stick_x;
    logic [AXIS_W-1:0]     stick_y;
    logic                  out_valid;
    logic                  out_stall;
    logic [BTN_W-1:0]      held;
    logic [BTN_W-1:0]      changed;
    logic [BTN_W-1:0]      pressed;
    logic                  any_active;
    logic [NUM_DIRS-1:0]   repeat_res;
    logic [CNT_W-1:0]      up_hold;
    logic [CNT_W-1:0]      right_hold;
    logic [CNT_W-1:0]      down_hold;
    logic [CNT_W-1:0]      left_hold;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Qualifier state as the block should hold it
    cfg_t pad_cfg = '{full_low: RST_FULL_LOW, half_low: RST_HALF_LOW,
                      half_high: RST_HALF_HIGH, full_high: RST_FULL_HIGH,
                      repeat_delay: RST_REPEAT_DLY};
    logic                            pulse_phase = 1'b0;
    logic [BTN_W-1:0]                last_held = '0;
    logic [NUM_DIRS-1:0][CNT_W-1:0]  dir_hold = '0;

    res_t expected_results[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   hold_off_cycles = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;

    gamepad_input_qualifier u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .buttons      (buttons),
        .other_active (other_active),
        .stick_x      (stick_x),
        .stick_y      (stick_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .held         (held),
        .changed      (changed),
        .pressed      (pressed),
        .any_active   (any_active),
        .repeat_res   (repeat_res),
        .up_hold      (up_hold),
        .right_hold   (right_hold),
        .down_hold    (down_hold),
        .left_hold    (left_hold),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Abort a run that has hung
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL gamepad_input_qualifier");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Zone of one axis: bit 0 low direction, bit 1 high direction
    function automatic logic [1:0] stick_zone(input logic [AXIS_W-1:0] v);
        if (v < pad_cfg.full_low)
            return 2'b01;
        if (v < pad_cfg.half_low)
            return {1'b0, pulse_phase};
        if (v < pad_cfg.half_high)
            return 2'b00;
        if (v < pad_cfg.full_high)
            return {pulse_phase, 1'b0};
        return 2'b10;
    endfunction

    // Qualify one poll and advance the phase, held word and hold counts
    function automatic res_t qualify_poll(input item_t p);
        res_t             r;
        logic [1:0]       zx;
        logic [1:0]       zy;
        logic [BTN_W-1:0] h;
        logic [BTN_W-1:0] c;
        logic [CNT_W-1:0] cnt;
        pulse_phase = ~pulse_phase;
        zx = stick_zone(p.stick_x);
        zy = stick_zone(p.stick_y);
        h = p.buttons;
        h[DIR_UP]    = h[DIR_UP] | zy[0];
        h[DIR_DOWN]  = h[DIR_DOWN] | zy[1];
        h[DIR_LEFT]  = h[DIR_LEFT] | zx[0];
        h[DIR_RIGHT] = h[DIR_RIGHT] | zx[1];
        c = h ^ last_held;
        last_held = h;
        r.held = h;
        r.changed = c;
        r.pressed = c & h;
        r.any_active = (h != '0) || p.other_active;
        r.repeat_res = '0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            cnt = dir_hold[d];
            if (h[d])
                cnt = cnt + 1'b1;
            if (c[d])
                cnt = '0;
            dir_hold[d] = cnt;
            r.hold_cnt[d] = cnt;
            r.repeat_res[d] = h[d] && (c[d] || (cnt > pad_cfg.repeat_delay &&
                              (cnt[2:0] & REPEAT_MOD_MASK) == 3'd0));
        end
        return r;
    endfunction

    function automatic item_t poll_of(input logic [BTN_W-1:0] b, input logic o,
                                      input logic [AXIS_W-1:0] x,
                                      input logic [AXIS_W-1:0] y);
        item_t p;
        p.buttons = b;
        p.other_active = o;
        p.stick_x = x;
        p.stick_y = y;
        return p;
    endfunction

    // Axis value: uniform, or close to one of the current thresholds
    function automatic logic [AXIS_W-1:0] pick_axis();
        logic [AXIS_W-1:0] thr;
        case ($urandom_range(0, 7))
            0: thr = pad_cfg.full_low;
            1: thr = pad_cfg.half_low;
            2: thr = pad_cfg.half_high;
            3: thr = pad_cfg.full_high;
            default: return AXIS_W'($urandom_range(0, 255));
        endcase
        return AXIS_W'(thr + $urandom_range(0, 2) - 1);
    endfunction

    function automatic item_t rand_poll();
        return poll_of(BTN_W'($urandom), 1'($urandom), pick_axis(), pick_axis());
    endfunction

    // Offer one poll and record its expected result once taken
    task automatic send_poll(input item_t p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        buttons      <= p.buttons;
        other_active <= p.other_active;
        stick_x      <= p.stick_x;
        stick_y      <= p.stick_y;
        // hold the request until the block takes it
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        expected_results.push_back(qualify_poll(p));
    endtask

    // Drop the request line and wait for every outstanding result
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one register, then read it back
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        logic [DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // idle the bus before the next transfer
        @(posedge clk);
        case (idx)
            REG_FULL_LOW:   pad_cfg.full_low = val;
            REG_HALF_LOW:   pad_cfg.half_low = val;
            REG_HALF_HIGH:  pad_cfg.half_high = val;
            REG_FULL_HIGH:  pad_cfg.full_high = val;
            REG_REPEAT_DLY: pad_cfg.repeat_delay = val;
            default: ;
        endcase
        if (idx <= REG_REPEAT_DLY)
            check_field($sformatf("register %0d readback", idx), rd, val);
    endtask

    task automatic program_cfg(input logic [7:0] fl, input logic [7:0] hl,
                               input logic [7:0] hh, input logic [7:0] fh,
                               input logic [7:0] dl);
        wait_drain();
        write_reg(REG_FULL_LOW, fl);
        write_reg(REG_HALF_LOW, hl);
        write_reg(REG_HALF_HIGH, hh);
        write_reg(REG_FULL_HIGH, fh);
        write_reg(REG_REPEAT_DLY, dl);
    endtask

    // Mostly steady holds with small button flicker, the rest single noisy polls
    task automatic run_random(input int n);
        int    left;
        int    len;
        item_t base;
        item_t p;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                base = rand_poll();
                len = $urandom_range(1, 40);
                if (len > left)
                    len = left;
                repeat (len)
                begin
                    p = base;
                    if ($urandom_range(0, 7) == 0)
                        p.buttons[$urandom_range(0, BTN_W - 1)] ^= 1'b1;
                    send_poll(p);
                end
                left -= len;
            end
            else
            begin
                send_poll(rand_poll());
                left--;
            end
        end
    endtask

    // Zone boundaries, button extremes, other-button flag, first repeat strobe
    task automatic test_directed();
        send_poll(poll_of(10'h000, 1'b0, 8'd128, 8'd128));
        send_poll(poll_of(10'h3FF, 1'b1, 8'd128, 8'd128));
        send_poll(poll_of(10'h000, 1'b1, 8'd128, 8'd128));
        send_poll(poll_of(10'h000, 1'b0, 8'd128, 8'd128));
        send_poll(poll_of(10'h000, 1'b0, 8'd0, 8'd0));
        send_poll(poll_of(10'h000, 1'b0, 8'd255, 8'd255));
        send_poll(poll_of(10'h000, 1'b0, 8'd15, 8'd15));
        send_poll(poll_of(10'h000, 1'b0, 8'd16, 8'd16));
        send_poll(poll_of(10'h000, 1'b0, 8'd63, 8'd63));
        send_poll(poll_of(10'h000, 1'b0, 8'd64, 8'd64));
        send_poll(poll_of(10'h000, 1'b0, 8'd191, 8'd191));
        send_poll(poll_of(10'h000, 1'b0, 8'd192, 8'd192));
        send_poll(poll_of(10'h000, 1'b0, 8'd239, 8'd239));
        send_poll(poll_of(10'h000, 1'b0, 8'd240, 8'd240));
        send_poll(poll_of(10'h155, 1'b0, 8'd128, 8'd128));
        send_poll(poll_of(10'h2AA, 1'b1, 8'd128, 8'd128));
        repeat (9)
            send_poll(poll_of(10'h001, 1'b0, 8'd128, 8'd128));
    endtask

    // Long holds: counts past the delay and through the wrap, pulsing zones
    task automatic test_repeat();
        tx_idle = 1'b0;
        repeat (300)
            send_poll(poll_of(10'h004, 1'b0, 8'd255, 8'd0));
        tx_idle = 1'b1;
        repeat (20)
            send_poll(poll_of(10'h000, 1'b0, 8'd40, 8'd200));
        repeat (20)
            send_poll(poll_of(10'h008, 1'b0, 8'd128, 8'd128));
    endtask

    // Hold off the result side so the block backs up, then pause the sender
    task automatic test_pressure();
        wait_drain();
        tx_idle = 1'b0;
        hold_off_cycles = 80;
        run_random(40);
        wait_drain();
        tx_idle = 1'b1;
        run_random(40);
    endtask

    task automatic test_config_sweep();
        program_cfg(8'd0, 8'd0, 8'd255, 8'd255, 8'd0);
        run_random(90);
        program_cfg(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        run_random(90);
        program_cfg(8'd128, 8'd64, 8'd192, 8'd100, 8'd3);
        run_random(90);
        program_cfg(8'd1, 8'd2, 8'd253, 8'd254, 8'd7);
        run_random(90);
        wait_drain();
        write_reg(REG_SPARE, 8'($urandom));
        run_random(90);
        program_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom_range(0, 20)));
        run_random(90);
    endtask

    task automatic test_random();
        program_cfg(RST_FULL_LOW, RST_HALF_LOW, RST_HALF_HIGH, RST_FULL_HIGH,
                    RST_REPEAT_DLY);
        repeat (6)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            run_random(110);
        end
    endtask

    // Result side: draw a stall before each result, or serve a long hold-off
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                n = rx_idle ? $urandom_range(0, 19) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    // Compare each result taken at the coming edge with the oldest expectation
    always @(negedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no poll outstanding");
            else
            begin
                want = expected_results.pop_front();
                check_field("held", held, want.held);
                check_field("changed", changed, want.changed);
                check_field("pressed", pressed, want.pressed);
                check_field("any_active", any_active, want.any_active);
                check_field("repeat_res", repeat_res, want.repeat_res);
                check_field("up_hold", up_hold, want.hold_cnt[DIR_UP]);
                check_field("right_hold", right_hold, want.hold_cnt[DIR_RIGHT]);
                check_field("down_hold", down_hold, want.hold_cnt[DIR_DOWN]);
                check_field("left_hold", left_hold, want.hold_cnt[DIR_LEFT]);
            end
        end
    end

    initial
    begin
        in_valid     <= 1'b0;
        buttons      <= '0;
        other_active <= 1'b0;
        stick_x      <= '0;
        stick_y      <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_repeat();
        test_pressure();
        test_config_sweep();
        test_random();
        wait_drain();
        // let any stray result surface
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS gamepad_input_qualifier");
        else
            $display("FAIL gamepad_input_qualifier");
        $finish;
    end

endmodule

FILE: files.f
rtl/gpq_pkg.sv
rtl/gpq_cfg.sv
rtl/gpq_core.sv
rtl/gamepad_input_qualifier.sv
dv/tb_top.sv
